@@ hw/rtl/glyph_row_bit_packer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Glyph row bit packer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ROW_BIT_PACKER_TOP_MACROS_SVH
`define GLYPH_ROW_BIT_PACKER_TOP_MACROS_SVH

// Same-cycle implication.
`define GRBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GRBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/grbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Glyph row bit packer package
// Shared constants and the word types passed from the packer to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package grbp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUT_WIDTH     = 32;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] word;
    logic                 run_last;
  } grbp_res_t;

  typedef struct packed {
    logic [1:0] n;
    grbp_res_t  a;
    grbp_res_t  b;
  } grbp_push_t;

endpackage

@@ hw/rtl/grbp_core.sv @@
// ----------------------------------------------------------------------------
// Glyph row bit packer core
// Input register, pending bit state and the single-pass shift-and-merge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glyph_row_bit_packer_top_macros.svh"

module grbp_core
  import grbp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_row_bits,
  input  logic [5:0]  in_row_width,
  input  logic        in_glyph_end,
  input  logic        room,
  output grbp_push_t  push
);

  localparam int W   = WORD_BITS;
  localparam int W2  = 2 * W;
  localparam int CW  = $clog2(W);
  localparam int SW  = CW + 2;
  localparam int LIM = (W < 32) ? W : 32;

  logic          item_vld_r, item_vld_nxt;
  logic [31:0]   row_bits_r;
  logic [5:0]    row_width_r;
  logic          glyph_end_r;
  logic [W-1:0]  pending_r, pending_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          accept;
  logic          fire;
  logic [5:0]    eff;
  logic [32:0]   mask33;
  logic [31:0]   bits32;
  logic [W2-1:0] bits2;
  logic [W2-1:0] comb;
  logic [W2-1:0] rmask;
  logic [SW-1:0] space;
  logic [SW-1:0] total;
  logic [SW-1:0] rem;
  logic          fits;
  logic [W-1:0]  word_full;
  logic [W-1:0]  word_fl;
  logic [W-1:0]  pend_a;
  logic [CW-1:0] cnt_a;
  logic          flush;

  assign fire     = item_vld_r && room;
  assign in_stall = item_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    eff       = (row_width_r > 6'(LIM)) ? 6'(LIM) : row_width_r;
    mask33    = (33'd1 << eff) - 33'd1;
    bits32    = row_bits_r & mask33[31:0];
    bits2     = W2'(bits32);
    comb      = ({{W{1'b0}}, pending_r} << eff) | bits2;
    space     = SW'(W) - SW'(count_r);
    total     = SW'(count_r) + SW'(eff);
    fits      = SW'(eff) < space;
    rem       = total - SW'(W);
    rmask     = (W2'(1) << rem) - W2'(1);
    word_full = W'(comb >> rem);
    if (fits) begin
      pend_a = comb[W-1:0];
      cnt_a  = CW'(total);
    end else begin
      pend_a = W'(bits2 & rmask);
      cnt_a  = CW'(rem);
    end
    flush   = glyph_end_r && (cnt_a != '0);
    word_fl = pend_a << (SW'(W) - SW'(cnt_a));
  end

  always_comb begin
    push.n          = fire ? (2'(!fits) + 2'(flush)) : 2'd0;
    push.b.word     = OUT_WIDTH'(word_fl);
    push.b.run_last = 1'b1;
    if (!fits) begin
      push.a.word     = OUT_WIDTH'(word_full);
      push.a.run_last = !flush;
    end else begin
      push.a.word     = OUT_WIDTH'(word_fl);
      push.a.run_last = 1'b1;
    end
  end

  always_comb begin
    item_vld_nxt = item_vld_r;
    pending_nxt  = pending_r;
    count_nxt    = count_r;
    if (fire) begin
      item_vld_nxt = 1'b0;
      pending_nxt  = flush ? '0 : pend_a;
      count_nxt    = flush ? '0 : cnt_a;
    end
    if (accept) begin
      item_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      pending_r  <= '0;
      count_r    <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      pending_r  <= pending_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_bits_r  <= in_row_bits;
      row_width_r <= in_row_width;
      glyph_end_r <= in_glyph_end;
    end
  end

  `GRBP_ASSERT_IMP(a_cnt_range, 1'b1, (SW'(count_r) < SW'(W)), "pending count out of range")
  `GRBP_ASSERT_NXT(a_flush_clears, fire && glyph_end_r, count_r == '0, "flush left bits pending")
  `GRBP_ASSERT_IMP(a_two_words, push.n == 2'd2, !push.a.run_last && push.b.run_last, "bad run_last")

endmodule

@@ hw/rtl/grbp_outq.sv @@
// ----------------------------------------------------------------------------
// Glyph row bit packer output queue
// Small queue taking up to two words per cycle while it has room and handing out one while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glyph_row_bit_packer_top_macros.svh"

module grbp_outq
  import grbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  grbp_push_t  push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_packed_word,
  output logic        out_run_last
);

  localparam int DEPTH = OUTQ_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = AW + 1;

  grbp_res_t       mem [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            pop;
  logic [AW-1:0]   wr_b;

  assign room            = count_r <= CNTW'(DEPTH - 2);
  assign out_valid       = count_r != '0;
  assign pop             = out_valid && !out_stall;
  assign out_packed_word = mem[rd_r].word;
  assign out_run_last    = mem[rd_r].run_last;
  assign wr_b            = wr_r + AW'(1);

  always_comb begin
    wr_nxt    = wr_r + AW'(push.n);
    rd_nxt    = pop ? rd_r + AW'(1) : rd_r;
    count_nxt = count_r + CNTW'(push.n) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem[wr_b] <= push.b;
    end
  end

  `GRBP_ASSERT_IMP(a_cnt_bound, 1'b1, (count_r <= CNTW'(DEPTH)), "queue count exceeds depth")
  `GRBP_ASSERT_IMP(a_no_overflow, push.n != 2'd0, count_r <= CNTW'(DEPTH - 2), "push without room")
  `GRBP_ASSERT_NXT(a_idle_hold, ((push.n == 2'd0) && !pop), $stable(count_r), "count moved while idle")

endmodule

@@ hw/rtl/glyph_row_bit_packer_top.sv @@
// An accepted row sits in the input register until the output queue has room for its words.
// One row per cycle is taken while each row yields at most one word and the queue has room.
// A row that yields a full word and a flushed word pushes both into the queue at once.
// The output queue of four words and the one-word-per-cycle output port set this rate.
// Reset clears the pending bits, the pending count, the input valid flag and the queue.
// ----------------------------------------------------------------------------
// Glyph row bit packer top level
// Packs glyph bitmap rows MSB first into a stream of 32-bit words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_row_bit_packer_top
  import grbp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_row_bits,
  input  logic [5:0]  in_row_width,
  input  logic        in_glyph_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_packed_word,
  output logic        out_run_last
);

  grbp_push_t push;
  logic       room;

  grbp_core #(
    .WORD_BITS(WORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_row_bits (in_row_bits),
    .in_row_width(in_row_width),
    .in_glyph_end(in_glyph_end),
    .room        (room),
    .push        (push)
  );

  grbp_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .room           (room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packed_word(out_packed_word),
    .out_run_last   (out_run_last)
  );

endmodule
